// File: src/rku_pkg.sv
// Package with shared constants and a Q2.14 saturation helper for the row upsampler.
`timescale 1ns / 1ps
package rku_pkg;
  localparam int DEF_MAX_ROW = 1024;
  localparam int DEF_MAX_FACTOR = 16;
  localparam int DEF_CHANNELS = 3;
  localparam int POS_W = 14;
  localparam int PIX_W = 8;

  localparam logic [1:0] KSEL_BOX = 2'd0;
  localparam logic [1:0] KSEL_TENT = 2'd1;
  localparam logic [1:0] KSEL_BELL = 2'd2;
  localparam logic [1:0] KSEL_MITCH = 2'd3;

  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_KSEL = 2'd1;
  localparam logic [1:0] REG_ROWLEN = 2'd2;

  // Saturate a wide signed value to Q2.14.
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

// File: src/rku_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module rku_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/rku_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rku_divider #(
  parameter int NW = 20,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0] rem;
  logic [CW-1:0] cnt;
  logic run;
  logic [DW:0] trial;
  always_comb trial = {rem[DW-1:0], q[NW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        q <= num;
        rem <= '0;
        cnt <= CW'(NW);
      end else if (run) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule

// File: src/row_kernel_upsampler.sv
// Top level of the row kernel upsampler: command port, config port and tap sequencer.
`timescale 1ns / 1ps
// Usage. Requests enter on start/busy: a request is accepted at a clock edge
// where start is high and busy is low. A load request (kind 0) writes one RGB
// pixel into the row store and produces no result. A compute
// request (kind 1) names an output column and produces exactly one result on
// out_column and the color ports, marked by a one-cycle strobe, done.
// Configuration writes use cfg_valid/cfg_ready with a register index
// (0 factor, 1 kernel select, 2 row length) and data; cfg_ready is always
// high and writes are meant to happen while the block is idle.
// Sequence: a compute first divides the column by the factor on a shared
// restoring divider (32 quotient bits). Each tap then reruns the divider for
// the kernel argument, uses a shared multiplier for the square and cube terms,
// forms the weight, and does one multiply-add per color channel. The right
// edge case takes a single multiply-add pass with unit weight on the last
// pixel of the row. Busy is high until the result cycle, so the next request
// can be accepted while the result is shown. The receiver cannot stall: a
// result is shown for one cycle only.
// Reset clears the sequencer and sets factor 2, tent kernel, row length
// 1024, clamped to MAX_ROW. The row store is not cleared; unwritten entries
// must not be read.
module row_kernel_upsampler
  import rku_pkg::*;
#(
  parameter int MAX_ROW = rku_pkg::DEF_MAX_ROW,
  parameter int MAX_FACTOR = rku_pkg::DEF_MAX_FACTOR,
  parameter int CHANNELS = rku_pkg::DEF_CHANNELS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [rku_pkg::POS_W-1:0] position,
  input  logic [7:0]                red_in,
  input  logic [7:0]                green_in,
  input  logic [7:0]                blue_in,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [10:0]               cfg_data,
  output logic                      done,
  output logic [rku_pkg::POS_W-1:0] out_column,
  output logic [7:0]                red_out,
  output logic [7:0]                green_out,
  output logic [7:0]                blue_out
);
  localparam int AW = $clog2(MAX_ROW);
  localparam int LW = $clog2(MAX_ROW + 1);
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int SW = CHANNELS * PIX_W;
  localparam int NW = 14 + 18;  // |d| * 2^14, |d| below 2^18
  localparam int XW = 19 + 14;  // signed tap position times factor range

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SETUP = 10'b0000000010,
    S_TAP = 10'b0000000100,
    S_DIV = 10'b0000001000,
    S_SQ = 10'b0000010000,
    S_CUBE = 10'b0000100000,
    S_POLY = 10'b0001000000,
    S_MAC = 10'b0010000000,
    S_EDGE = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;

  state_t state;
  logic [4:0] factor;
  logic [1:0] kernel_select;
  logic [10:0] row_length;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= 5'd2;
      kernel_select <= KSEL_TENT;
      row_length <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FACTOR: factor <= cfg_data[4:0];
        REG_KSEL: kernel_select <= cfg_data[1:0];
        REG_ROWLEN: row_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective factor and row length after clamping.
  logic [FW-1:0] f_eff;
  logic [LW-1:0] len_eff;
  always_comb begin
    if (factor == 5'd0) f_eff = FW'(1);
    else if (32'(factor) > MAX_FACTOR) f_eff = FW'(MAX_FACTOR);
    else f_eff = FW'(factor);
    if (row_length == 11'd0) len_eff = LW'(1);
    else if (32'(row_length) > MAX_ROW) len_eff = LW'(MAX_ROW);
    else len_eff = LW'(row_length);
  end

  // Row store.
  logic ram_we;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rdata, wdata;
  always_comb begin
    wdata = '0;
    wdata[7:0] = red_in;
    if (CHANNELS > 1) wdata[PIX_W*(CHANNELS>1?1:0) +: PIX_W] = green_in;
    if (CHANNELS > 2) wdata[PIX_W*(CHANNELS>2?2:0) +: PIX_W] = blue_in;
  end
  assign ram_we = start && !busy && !kind && (32'(position) < MAX_ROW);
  rku_ram #(.WIDTH(SW), .DEPTH(MAX_ROW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(position[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Request registers.
  logic [POS_W-1:0] p_reg;
  logic [FW-1:0] f_reg;
  logic [1:0] ks_reg;
  logic [2:0] w_reg;
  logic [LW-1:0] len_reg;
  logic signed [LW:0] k, right;

  // Shared divider: computes p/f, then |d|*2^14/f per tap.
  logic div_go, div_done;
  logic [NW-1:0] div_num, div_q;
  rku_divider #(.NW(NW), .DW(FW)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(f_reg),
    .done(div_done), .quo(div_q)
  );
  logic base_phase;

  // Tap window around the base column before clipping to the row.
  logic signed [LW+1:0] lo_tap, hi_tap;
  always_comb begin
    lo_tap = $signed({1'b0, div_q[LW:0]}) - $signed((LW+2)'(w_reg));
    hi_tap = $signed({1'b0, div_q[LW:0]}) + $signed((LW+2)'(w_reg));
  end

  // Tap offset d = k*f - p (small multiply by narrow factor).
  logic signed [XW-1:0] d;
  logic [XW-1:0] ad;
  always_comb begin
    d = XW'(k) * $signed({1'b0, f_reg}) - $signed(XW'(p_reg));
    ad = d[XW-1] ? XW'(-d) : XW'(d);
  end
  logic box_hit;
  assign box_hit = (2 * d >= -$signed({1'b0, XW'(f_reg)})) &&
                   (2 * d < $signed({1'b0, XW'(f_reg)}));

  // Shared multiplier operands; u is clipped so only meaningful ranges matter.
  logic [17:0] u;
  logic [35:0] mul_p;
  logic [17:0] ma, mb;
  assign mul_p = ma * mb;
  logic [19:0] x2, x3;
  logic signed [15:0] wt;
  logic signed [23:0] acc [CHANNELS];
  logic [1:0] ch;

  // Polynomial terms using constant multiplies on stored x2/x3/u.
  logic signed [39:0] wv;
  always_comb begin
    wv = '0;
    case (ks_reg)
      KSEL_BOX: wv = box_hit ? 40'sd16384 : 40'sd0;
      KSEL_TENT: wv = (u < 18'd16384) ? 40'sd16384 - 40'(u) : 40'sd0;
      KSEL_BELL: begin
        if (u <= 18'd8192) wv = 40'sd12288 - 40'(x2);
        else if (u <= 18'd24576) wv = 40'(x3);  // x3 holds (t*t)>>15 here
      end
      default: begin
        if (u < 18'd16384)
          wv = 40'((40'(x3) * 19115) >> 14) - 40'(2 * 40'(x2)) + 40'sd14564;
        else if (u <= 18'd32768)
          wv = -40'((40'(x3) * 6372) >> 14) + 40'(2 * 40'(x2))
               - 40'((40'(u) * 54613) >> 14) + 40'sd29127;
      end
    endcase
  end

  logic signed [8+16:0] prod;
  logic signed [25:0] sum;
  logic [7:0] pix;
  always_comb begin
    pix = rdata[PIX_W*ch +: PIX_W];
    prod = $signed({1'b0, pix}) * wt;
    sum = 26'(acc[ch]) + 26'(prod);
  end

  function automatic logic [7:0] clip(input logic signed [23:0] a);
    logic [7:0] r;
    if (a <= 0) r = 8'd0;
    else if (a[23:14] > 10'd255) r = 8'd255;
    else r = a[21:14];
    return r;
  endfunction

  logic [7:0] col [3];
  always_comb begin
    for (int i = 0; i < 3; i++) col[i] = (i < CHANNELS) ? clip(acc[i]) : 8'd0;
  end

  logic signed [19:0] edge_lim;
  logic [LW+FW-1:0] cols_p;
  assign cols_p = len_eff * f_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: if (start && kind) begin
          p_reg <= position;
          f_reg <= f_eff;
          ks_reg <= kernel_select;
          w_reg <= 3'(kernel_select) + 3'd1;
          len_reg <= len_eff;
          edge_lim <= 20'(cols_p) - 20'(position);
          for (int i = 0; i < CHANNELS; i++) acc[i] <= '0;
          state <= S_SETUP;
        end
        S_SETUP: begin
          // Columns past the scaled row are negative here and take the edge path.
          if (edge_lim < $signed(20'(f_reg) + 20'(w_reg) - 20'd1)) begin
            raddr <= AW'(len_reg - 1'b1);
            state <= S_EDGE;
          end else begin
            div_num <= NW'(p_reg);
            div_go <= 1'b1;
            base_phase <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          if (base_phase) begin
            base_phase <= 1'b0;
            k <= (lo_tap < 0) ? '0 : lo_tap[LW:0];
            right <= (hi_tap >= $signed((LW+2)'(len_reg))) ?
                     $signed((LW+1)'(len_reg - 1'b1)) : hi_tap[LW:0];
            state <= S_TAP;
          end else begin
            u <= (div_q > NW'(18'h3ffff)) ? 18'h3ffff : div_q[17:0];
            ma <= (div_q > NW'(18'h3ffff)) ? 18'h3ffff : div_q[17:0];
            mb <= (div_q > NW'(18'h3ffff)) ? 18'h3ffff : div_q[17:0];
            state <= S_SQ;
          end
        end
        S_TAP: begin
          if (k > right) state <= S_OUT;
          else begin
            raddr <= AW'(k);
            div_num <= NW'(ad) << 14;
            div_go <= 1'b1;
            state <= S_DIV;
          end
        end
        S_SQ: begin
          x2 <= 20'(mul_p >> 14);
          if (ks_reg == KSEL_BELL) begin
            ma <= 18'd24576 - u;
            mb <= 18'd24576 - u;
          end else begin
            ma <= 18'(mul_p >> 14);
            mb <= u;
          end
          state <= S_CUBE;
        end
        S_CUBE: begin
          x3 <= (ks_reg == KSEL_BELL) ? 20'(mul_p >> 15) : 20'(mul_p >> 14);
          state <= S_POLY;
        end
        S_POLY: begin
          wt <= sat16(wv);
          ch <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (sum > 26'sd8388607) acc[ch] <= 24'sd8388607;
          else if (sum < -26'sd8388608) acc[ch] <= -24'sd8388608;
          else acc[ch] <= sum[23:0];
          if (32'(ch) == CHANNELS - 1) begin
            k <= k + 1'b1;
            state <= S_TAP;
          end else ch <= ch + 1'b1;
        end
        S_EDGE: begin
          // One pass of the multiply-add with unit weight, then straight out.
          wt <= 16'sd16384;
          ch <= '0;
          k <= (LW+1)'(1);
          right <= '0;
          state <= S_MAC;
        end
        S_OUT: begin
          done <= 1'b1;
          out_column <= p_reg;
          red_out <= col[0];
          green_out <= col[1];
          blue_out <= col[2];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
endmodule

// File: src/rku_checker.sv
// Port-level checker for the row upsampler, bound to the top level.
`timescale 1ns / 1ps
module rku_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done,
  input logic cfg_ready
);
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held two cycles");
  a_idle_at_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy during result");
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind) |=> busy) else $error("compute not started");
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !kind) |=> !busy) else $error("load made block busy");
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

bind row_kernel_upsampler rku_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
  .done(done), .cfg_ready(cfg_ready)
);
